/* hw/rtl/mdsu_pkg.sv */
// shared types and constants for the sample dump packet unpacker
// used by mdsu_in_reg, mdsu_core and midi_sample_dump_packet_unpacker
package mdsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 32;
  localparam int unsigned PosW    = 7;
  localparam int unsigned DepthW  = 5;

  localparam logic [ByteW-1:0] StartHi = 8'hF0;
  localparam logic [ByteW-1:0] StartLo = 8'h7E;
  localparam logic [ByteW-1:0] EndByte = 8'hF7;

  localparam logic [PosW-1:0] PosFirst     = 7'd0;
  localparam logic [PosW-1:0] PosSecond    = 7'd1;
  localparam logic [PosW-1:0] PosDataFirst = 7'd5;
  localparam logic [PosW-1:0] PosCheck     = 7'd125;
  localparam logic [PosW-1:0] PosEnd       = 7'd126;

  localparam logic [DepthW-1:0] DepthReset     = 5'd8;
  localparam logic [DepthW-1:0] DepthTwoBelow   = 5'd14;
  localparam logic [DepthW-1:0] DepthThreeBelow = 5'd21;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_BAD_START = 2'd2,
    KIND_BAD_END   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    kind_e              kind;
  } result_t;

  // left shift of a data byte by its place in the group
  function automatic logic [4:0] group_shift(input logic [1:0] n);
    logic [4:0] s;
    case (n)
      2'd0:    s = 5'd25;
      2'd1:    s = 5'd18;
      2'd2:    s = 5'd11;
      default: s = 5'd4;
    endcase
    return s;
  endfunction

  // bytes per sample for a bit depth
  function automatic logic [2:0] group_size(input logic [DepthW-1:0] depth);
    logic [2:0] g;
    if (depth < DepthTwoBelow) begin
      g = 3'd2;
    end else if (depth < DepthThreeBelow) begin
      g = 3'd3;
    end else begin
      g = 3'd4;
    end
    return g;
  endfunction

endpackage

/* hw/rtl/mdsu_in_reg.sv */
// input register stage of the sample dump packet unpacker
// depends on mdsu_pkg
module mdsu_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mdsu_pkg::ByteW-1:0] in_byte_i,
  input  logic                      step_i,
  output logic                      hold_valid_o,
  output logic [mdsu_pkg::ByteW-1:0] hold_byte_o
);

  logic                      valid_q, valid_d;
  logic [mdsu_pkg::ByteW-1:0] byte_q;
  logic                      load;

  assign in_ready_o = !valid_q || step_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (step_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign hold_valid_o = valid_q;
  assign hold_byte_o  = byte_q;

endmodule

/* hw/rtl/mdsu_core.sv */
// packet position tracking and sample assembly, one byte per step
// depends on mdsu_pkg
module mdsu_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [mdsu_pkg::ByteW-1:0]  byte_i,
  input  logic [mdsu_pkg::DepthW-1:0] depth_i,
  output logic                        res_valid_o,
  output mdsu_pkg::result_t           res_o
);

  logic [mdsu_pkg::PosW-1:0]    pos_q, pos_d;
  logic [mdsu_pkg::ByteW-1:0]   first_q, first_d;
  logic [mdsu_pkg::SampleW-1:0] acc_q, acc_d;
  logic [1:0]                   cnt_q, cnt_d;

  logic [2:0]                   gsize;
  logic [2:0]                   cnt_inc;
  logic [mdsu_pkg::SampleW-1:0] part;
  logic [mdsu_pkg::SampleW-1:0] acc_new;

  assign gsize   = mdsu_pkg::group_size(depth_i);
  assign cnt_inc = {1'b0, cnt_q} + 3'd1;
  assign part    = {{(mdsu_pkg::SampleW-mdsu_pkg::ByteW){1'b0}}, byte_i}
                   << mdsu_pkg::group_shift(cnt_q);
  assign acc_new = (gsize == 3'd2) ? (acc_q + part) : (acc_q | part);

  always_comb begin
    pos_d        = pos_q;
    first_d      = first_q;
    acc_d        = acc_q;
    cnt_d        = cnt_q;
    res_valid_o  = 1'b0;
    res_o.sample = '0;
    res_o.kind   = mdsu_pkg::KIND_SAMPLE;
    if (pos_q == mdsu_pkg::PosFirst) begin
      first_d = byte_i;
      acc_d   = '0;
      cnt_d   = 2'd0;
      pos_d   = mdsu_pkg::PosSecond;
    end else if (pos_q == mdsu_pkg::PosSecond) begin
      if (first_q != mdsu_pkg::StartHi || byte_i != mdsu_pkg::StartLo) begin
        pos_d       = mdsu_pkg::PosFirst;
        res_valid_o = 1'b1;
        res_o.kind  = mdsu_pkg::KIND_BAD_START;
      end else begin
        pos_d = pos_q + 7'd1;
      end
    end else if (pos_q >= mdsu_pkg::PosEnd) begin
      pos_d       = mdsu_pkg::PosFirst;
      res_valid_o = 1'b1;
      res_o.kind  = (byte_i == mdsu_pkg::EndByte) ? mdsu_pkg::KIND_DONE
                                                  : mdsu_pkg::KIND_BAD_END;
    end else begin
      pos_d = pos_q + 7'd1;
      if (pos_q >= mdsu_pkg::PosDataFirst && pos_q < mdsu_pkg::PosCheck) begin
        if (cnt_inc >= gsize) begin
          acc_d        = '0;
          cnt_d        = 2'd0;
          res_valid_o  = 1'b1;
          res_o.sample = acc_new;
        end else begin
          acc_d = acc_new;
          cnt_d = cnt_inc[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      first_q <= first_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hw/rtl/midi_sample_dump_packet_unpacker.sv */
// top level of the sample dump packet unpacker: config register, result register
// depends on mdsu_pkg, mdsu_in_reg and mdsu_core
//
// Takes one packet byte per clock on the input stream while the output side takes
// results, and gives one result per sample or per packet status on the output
// stream. A byte passes an input register, then the parse and sample assembly
// logic, then a result register. Bytes that make no result (header, checksum,
// partial groups) leave nothing on the output.
// Results: tuser 0 a sample, 1 packet ended well, 2 bad start word (the next
// byte is taken as a new packet start), 3 bad terminator. The user must write
// bit depth over the cfg channel only while the block is idle; the block
// itself does not enforce it.
module midi_sample_dump_packet_unpacker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,     // sample depth
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // sample
  output logic [1:0]  m_axis_tuser    // kind
);

  logic [mdsu_pkg::DepthW-1:0] depth_q;
  logic                        hold_valid;
  logic [mdsu_pkg::ByteW-1:0]  hold_byte;
  logic                        step;
  logic                        res_valid;
  mdsu_pkg::result_t           res;
  logic                        out_valid_q, out_valid_d;
  mdsu_pkg::result_t           out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= mdsu_pkg::DepthReset;
    end else if (cfg_valid_i) begin
      depth_q <= cfg_data_i;
    end
  end

  // advance when the input register holds a byte and the result register is free or being emptied
  assign step = hold_valid && (!out_valid_q || m_axis_tready);

  mdsu_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .step_i       (step),
    .hold_valid_o (hold_valid),
    .hold_byte_o  (hold_byte)
  );

  mdsu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (hold_byte),
    .depth_i     (depth_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.sample;
  assign m_axis_tuser  = out_q.kind;

endmodule
